// File: hw/rtl/crcfr_pkg.sv
`timescale 1ns / 1ps

package crcfr_pkg;

    // Frame head layout: header byte at offset 0, length complete at offset 9.
    localparam int unsigned HEAD_LAST = 9;
    localparam int unsigned OFS_VERSION = 1;
    localparam int unsigned OFS_INDEX_LO = 2;
    localparam int unsigned OFS_INDEX_HI = 3;
    localparam int unsigned OFS_SERVICE = 4;
    localparam int unsigned OFS_COMMAND = 5;
    localparam int unsigned OFS_FLAGS_LO = 6;
    localparam int unsigned OFS_FLAGS_HI = 7;
    localparam int unsigned OFS_LEN_LO = 8;

    // Head bytes plus CRC bytes that count against the frame limit.
    localparam int unsigned FRAME_OVERHEAD = 14;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // End-of-frame status codes.
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_VERSION = 2'd1;
    localparam logic [1:0] ST_BAD_CRC = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // Receiver phase.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEAD,
        PH_PAYLOAD,
        PH_CRC
    } phase_t;

    // One result item.
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [11:0] payload_index;
        logic [1:0]  status;
        logic [7:0]  service_id;
        logic [7:0]  command_id;
        logic [15:0] packet_index;
        logic [15:0] frame_flags;
        logic [15:0] payload_length;
    } result_t;

    // Reflected CRC-32 update by one byte, bit at a time.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/crcfr_in_if.sv
`timescale 1ns / 1ps

// Byte stream channel into the receiver.
interface crcfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/crcfr_out_if.sv
`timescale 1ns / 1ps

// Result channel out of the receiver.
interface crcfr_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [11:0] payload_index;
    logic [1:0]  status;
    logic [7:0]  service_id;
    logic [7:0]  command_id;
    logic [15:0] packet_index;
    logic [15:0] frame_flags;
    logic [15:0] payload_length;

    modport source (
        output valid, output kind, output payload_byte, output payload_index,
        output status, output service_id, output command_id, output packet_index,
        output frame_flags, output payload_length, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input payload_index,
        input status, input service_id, input command_id, input packet_index,
        input frame_flags, input payload_length, output ready
    );
endinterface

// File: hw/rtl/crcfr_engine.sv
`timescale 1ns / 1ps

module crcfr_engine
    import crcfr_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 4096
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] header_byte,
    input  logic       in_fire,
    input  logic [7:0] rx_byte,
    output logic       res_push,
    output result_t    res
);

    localparam int unsigned PW = $clog2(MAX_FRAME);
    localparam logic [16:0] LEN_LIMIT = 17'(MAX_FRAME - FRAME_OVERHEAD);

    phase_t        phase_reg, phase_next;
    logic [3:0]    head_cnt_reg, head_cnt_next;
    logic [PW-1:0] pay_cnt_reg, pay_cnt_next;
    logic [1:0]    crcb_cnt_reg, crcb_cnt_next;
    logic [31:0]   crc_reg, crc_next;
    logic [31:0]   crc_rx_reg, crc_rx_next;
    logic [7:0]    version_reg, version_next;
    logic [7:0]    service_reg, service_next;
    logic [7:0]    command_reg, command_next;
    logic [15:0]   index_reg, index_next;
    logic [15:0]   flags_reg, flags_next;
    logic [15:0]   length_reg, length_next;

    logic [31:0] crc_upd;
    logic [16:0] pay_ext;
    logic [16:0] pay_inc;
    logic [31:0] crc_full;
    logic        frame_clear;

    assign crc_upd = crc_byte(crc_reg, rx_byte);
    assign pay_ext = 17'(pay_cnt_reg);
    assign pay_inc = pay_ext + 17'd1;
    assign crc_full = {rx_byte, crc_rx_reg[23:0]};

    // Phase, head field capture, CRC update and result for one accepted byte.
    always_comb
    begin
        phase_next = phase_reg;
        head_cnt_next = head_cnt_reg;
        pay_cnt_next = pay_cnt_reg;
        crcb_cnt_next = crcb_cnt_reg;
        crc_next = crc_reg;
        crc_rx_next = crc_rx_reg;
        version_next = version_reg;
        service_next = service_reg;
        command_next = command_reg;
        index_next = index_reg;
        flags_next = flags_reg;
        length_next = length_reg;
        frame_clear = 1'b0;
        res_push = 1'b0;
        res.kind = KIND_PAYLOAD;
        res.payload_byte = 8'd0;
        res.payload_index = 12'd0;
        res.status = ST_OK;

        if (in_fire)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == header_byte)
                    begin
                        phase_next = PH_HEAD;
                        head_cnt_next = 4'd1;
                        crc_next = crc_byte(CRC_INIT, rx_byte);
                    end
                end
                PH_HEAD:
                begin
                    crc_next = crc_upd;
                    head_cnt_next = head_cnt_reg + 4'd1;
                    case (head_cnt_reg)
                        4'(OFS_VERSION):  version_next = rx_byte;
                        4'(OFS_INDEX_LO): index_next = {8'd0, rx_byte};
                        4'(OFS_INDEX_HI): index_next = {rx_byte, index_reg[7:0]};
                        4'(OFS_SERVICE):  service_next = rx_byte;
                        4'(OFS_COMMAND):  command_next = rx_byte;
                        4'(OFS_FLAGS_LO): flags_next = {8'd0, rx_byte};
                        4'(OFS_FLAGS_HI): flags_next = {rx_byte, flags_reg[7:0]};
                        4'(OFS_LEN_LO):   length_next = {8'd0, rx_byte};
                        default:          length_next = {rx_byte, length_reg[7:0]};
                    endcase
                    if (head_cnt_reg == 4'(HEAD_LAST))
                    begin
                        pay_cnt_next = '0;
                        crcb_cnt_next = 2'd0;
                        if ({1'b0, length_next} > LEN_LIMIT)
                        begin
                            res_push = 1'b1;
                            res.kind = KIND_STATUS;
                            res.status = ST_TOO_LONG;
                            frame_clear = 1'b1;
                        end
                        else if (length_next == 16'd0)
                        begin
                            phase_next = PH_CRC;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    crc_next = crc_upd;
                    pay_cnt_next = pay_inc[PW-1:0];
                    res_push = 1'b1;
                    res.kind = KIND_PAYLOAD;
                    res.payload_byte = rx_byte;
                    res.payload_index = pay_ext[11:0];
                    if (pay_inc == {1'b0, length_reg})
                    begin
                        phase_next = PH_CRC;
                    end
                end
                default:
                begin
                    // Trailing CRC, least significant byte first.
                    crcb_cnt_next = crcb_cnt_reg + 2'd1;
                    case (crcb_cnt_reg)
                        2'd0:    crc_rx_next = {24'd0, rx_byte};
                        2'd1:    crc_rx_next = {16'd0, rx_byte, crc_rx_reg[7:0]};
                        2'd2:    crc_rx_next = {8'd0, rx_byte, crc_rx_reg[15:0]};
                        default: crc_rx_next = crc_full;
                    endcase
                    if (crcb_cnt_reg == 2'd3)
                    begin
                        res_push = 1'b1;
                        res.kind = KIND_STATUS;
                        if (version_reg != 8'd0)
                        begin
                            res.status = ST_BAD_VERSION;
                        end
                        else if ((crc_reg ^ CRC_INIT) != crc_full)
                        begin
                            res.status = ST_BAD_CRC;
                        end
                        else
                        begin
                            res.status = ST_OK;
                        end
                        frame_clear = 1'b1;
                    end
                end
            endcase
        end

        // Head fields as they stand after this byte go with every result.
        res.service_id = service_next;
        res.command_id = command_next;
        res.packet_index = index_next;
        res.frame_flags = flags_next;
        res.payload_length = length_next;

        if (frame_clear)
        begin
            phase_next = PH_IDLE;
            head_cnt_next = 4'd0;
            crc_next = CRC_INIT;
            crc_rx_next = 32'd0;
            version_next = 8'd0;
            service_next = 8'd0;
            command_next = 8'd0;
            index_next = 16'd0;
            flags_next = 16'd0;
            length_next = 16'd0;
        end
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            head_cnt_reg <= 4'd0;
            pay_cnt_reg <= '0;
            crcb_cnt_reg <= 2'd0;
            crc_reg <= CRC_INIT;
            crc_rx_reg <= 32'd0;
            version_reg <= 8'd0;
            service_reg <= 8'd0;
            command_reg <= 8'd0;
            index_reg <= 16'd0;
            flags_reg <= 16'd0;
            length_reg <= 16'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            head_cnt_reg <= head_cnt_next;
            pay_cnt_reg <= pay_cnt_next;
            crcb_cnt_reg <= crcb_cnt_next;
            crc_reg <= crc_next;
            crc_rx_reg <= crc_rx_next;
            version_reg <= version_next;
            service_reg <= service_next;
            command_reg <= command_next;
            index_reg <= index_next;
            flags_reg <= flags_next;
            length_reg <= length_next;
        end
    end

endmodule

// File: hw/rtl/crcfr_out_buf.sv
`timescale 1ns / 1ps

module crcfr_out_buf
    import crcfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_res,
    output logic    push_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    main_free;

    // Upstream stalls only once the skid entry is holding an item.
    assign push_ready = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res = main_reg;
    assign main_free = !main_valid_reg || out_ready;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_res;
        end
        if (!main_free && push)
        begin
            skid_reg <= push_res;
        end
    end

endmodule

// File: hw/rtl/crc32_checked_frame_receiver.sv
`timescale 1ns / 1ps

// Frame receiver for a byte stream with a length-prefixed head and a trailing
// CRC-32. It takes one byte per clock and never stalls the input while results
// are being taken: each byte is handled in the cycle it is accepted, and its
// result (if any) is registered into a two-entry output buffer. Bytes
// are dropped until one equals header_byte, then a 10-byte head is collected,
// the payload bytes are passed out one item each with their index, and after
// the four CRC bytes one status item reports ok, bad version, or bad CRC.
// A payload length above MAX_FRAME - 14 gives a too-long status right after
// the head and the receiver goes back to hunting for the header byte.
// header_byte is written over the APB port at address 0 and should only be
// changed between frames.
module crc32_checked_frame_receiver
    import crcfr_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    crcfr_in_if.sink          frame_in,
    crcfr_out_if.source       frame_out
);

    logic [7:0] header_byte_reg;
    logic       hdr_sel;
    logic       in_fire;
    logic       res_push;
    logic       push_ready;
    result_t    res;
    result_t    out_res;

    // Configuration register access; the low address bits select bytes only.
    assign hdr_sel = (paddr[2] == 1'b0);
    assign pready = 1'b1;
    assign prdata = hdr_sel ? {24'd0, header_byte_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_byte_reg <= 8'd0;
        end
        else if (psel && penable && pwrite && hdr_sel)
        begin
            header_byte_reg <= pwdata[7:0];
        end
    end

    // Input handshake.
    assign frame_in.ready = push_ready;
    assign in_fire = frame_in.valid && push_ready;

    crcfr_engine #(
        .MAX_FRAME (MAX_FRAME)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .header_byte (header_byte_reg),
        .in_fire     (in_fire),
        .rx_byte     (frame_in.rx_byte),
        .res_push    (res_push),
        .res         (res)
    );

    crcfr_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_push),
        .push_res   (res),
        .push_ready (push_ready),
        .out_valid  (frame_out.valid),
        .out_ready  (frame_out.ready),
        .out_res    (out_res)
    );

    // Result fields onto the output channel.
    assign frame_out.kind = out_res.kind;
    assign frame_out.payload_byte = out_res.payload_byte;
    assign frame_out.payload_index = out_res.payload_index;
    assign frame_out.status = out_res.status;
    assign frame_out.service_id = out_res.service_id;
    assign frame_out.command_id = out_res.command_id;
    assign frame_out.packet_index = out_res.packet_index;
    assign frame_out.frame_flags = out_res.frame_flags;
    assign frame_out.payload_length = out_res.payload_length;

endmodule
